[rtl/pts_pkg.sv]
// Shared types and constants of the periodic task tick scheduler.
`timescale 1ns / 1ps

package pts_pkg;

  // Default number of task slots
  localparam int unsigned PTS_MAX_TASKS = 8;

  // Fixed field widths
  localparam int unsigned DIV_W  = 20;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned MASK_W = 8;
  localparam int unsigned SLOT_W = 3;

  localparam logic [DIV_W-1:0] DIVIDER_RESET = 20'd7843;

  // Request codes on the input channel
  typedef enum logic [1:0] {
    ACT_REGISTER = 2'd0,
    ACT_OVERFLOW = 2'd1,
    ACT_CHECK    = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  // Operations handed to the slot table
  typedef enum logic {
    TOP_REGISTER = 1'b0,
    TOP_TICK     = 1'b1
  } table_op_e;

  // Request into the slot table
  typedef struct packed {
    logic             valid;
    table_op_e        op;
    logic [CNT_W-1:0] first_count;
    logic [CNT_W-1:0] period;
  } tbl_req_t;

  // Status out of the slot table
  typedef struct packed {
    logic              busy;
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] free_slot;
    logic [MASK_W-1:0] due_mask;
  } tbl_stat_t;

endpackage

[rtl/pts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pts_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pts_prescaler.sv]
// Tick divider register and overflow prescaler.
`timescale 1ns / 1ps

module pts_prescaler (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [pts_pkg::DIV_W-1:0] cfg_data_i,
  input  logic                     step_i,
  output logic                     tick_o
);

  import pts_pkg::*;

  logic [DIV_W-1:0] div_q;
  logic [DIV_W-1:0] count_q, count_d;
  logic [DIV_W-1:0] count_dec;
  logic [DIV_W-1:0] reload;

  // Decrement; a divider of zero reloads as one
  always_comb begin
    count_dec = count_q - DIV_W'(1);
    reload    = (div_q == '0) ? DIV_W'(1) : div_q;
    tick_o    = step_i && (count_dec == '0);
    count_d   = count_q;
    if (step_i) begin
      count_d = tick_o ? reload : count_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q   <= DIVIDER_RESET;
      count_q <= DIVIDER_RESET;
    end else begin
      if (cfg_we_i) begin
        div_q <= cfg_data_i;
      end
      count_q <= count_d;
    end
  end

endmodule

[rtl/pts_slot_table.sv]
// Task slot table: slot RAM, used bits and the tick walk sequencer.
`timescale 1ns / 1ps

module pts_slot_table #(
  parameter int unsigned MAX_TASKS = pts_pkg::PTS_MAX_TASKS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pts_pkg::tbl_req_t  req_i,
  output pts_pkg::tbl_stat_t stat_o
);

  import pts_pkg::*;

  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned PAD_W = (MAX_TASKS < MASK_W) ? MASK_W : MAX_TASKS;
  localparam int unsigned ENT_W = 2 * CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } walk_e;

  walk_e            state_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             pend_q;
  logic [IDX_W-1:0] pend_idx_q;
  logic [MAX_TASKS-1:0] used_q;
  logic [MAX_TASKS-1:0] one_q;

  logic             found;
  logic [IDX_W-1:0] free_idx;
  logic [SLOT_W-1:0] free_slot;
  logic             do_reg;
  logic             do_tick;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic             ram_re;
  logic [ENT_W-1:0] ram_rdata;

  logic [CNT_W-1:0] cur_cnt;
  logic [CNT_W-1:0] cur_reload;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] cnt_new;
  logic             upd_slot;
  logic [PAD_W-1:0] hit_pad;

  assign do_reg  = req_i.valid && (req_i.op == TOP_REGISTER);
  assign do_tick = req_i.valid && (req_i.op == TOP_TICK);

  // Lowest free slot
  always_comb begin
    found     = 1'b0;
    free_idx  = '0;
    free_slot = '0;
    for (int s = MAX_TASKS - 1; s >= 0; s--) begin
      if (!used_q[s]) begin
        found     = 1'b1;
        free_idx  = IDX_W'(s);
        free_slot = SLOT_W'(s);
      end
    end
  end

  // Countdown update for the entry read last cycle
  always_comb begin
    {cur_cnt, cur_reload} = ram_rdata;
    cnt_dec  = cur_cnt - CNT_W'(1);
    cnt_new  = (cnt_dec == '0) ? cur_reload : cnt_dec;
    upd_slot = pend_q && used_q[pend_idx_q];
  end

  // RAM ports: registration and walk write-back never overlap
  always_comb begin
    ram_re    = (state_q == ST_WALK);
    ram_we    = 1'b0;
    ram_waddr = pend_idx_q;
    ram_wdata = {cnt_new, cur_reload};
    if (do_reg && found) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx;
      ram_wdata = {req_i.first_count, req_i.period};
    end else if (upd_slot) begin
      ram_we = 1'b1;
    end
  end

  pts_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Walk sequencer and per-slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_idx_q   <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      used_q     <= '0;
      one_q      <= '0;
    end else begin
      pend_q     <= (state_q == ST_WALK);
      pend_idx_q <= rd_idx_q;
      case (state_q)
        ST_IDLE: begin
          if (do_tick) begin
            state_q  <= ST_WALK;
            rd_idx_q <= '0;
          end
        end
        ST_WALK: begin
          if (rd_idx_q == LAST_IDX) begin
            state_q <= ST_DRAIN;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
        end
        ST_DRAIN: state_q <= ST_DONE;
        ST_DONE:  state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
      if (do_reg && found) begin
        used_q[free_idx] <= 1'b1;
        one_q[free_idx]  <= (req_i.first_count == CNT_W'(1));
      end
      if (upd_slot) begin
        one_q[pend_idx_q] <= (cnt_new == CNT_W'(1));
      end
    end
  end

  // Due mask covers the first eight slots only
  assign hit_pad = PAD_W'(used_q & one_q);

  assign stat_o.busy      = (state_q != ST_IDLE);
  assign stat_o.done      = (state_q == ST_DONE);
  assign stat_o.found     = found;
  assign stat_o.free_slot = free_slot;
  assign stat_o.due_mask  = hit_pad[MASK_W-1:0];

endmodule

[rtl/periodic_task_tick_scheduler.sv]
// Top level of the periodic task tick scheduler.
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o    action_i, first_count_i, period_i
// out      output     out_valid_o / out_stall_i  due_mask_o, tick_fired_o,
//                                                assigned_slot_o, table_full_o
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_data_i (tick_divider)
//
// Register, check, idle and non-ticking overflow requests give their result
// in the cycle after acceptance. A ticking overflow walks the slot RAM one
// slot per cycle, then passes through the drain and done states before its
// result is registered. Reset marks all slots free; the RAM needs no
// clearing pass. The input stalls during a walk and while a held result is
// stalled.

module periodic_task_tick_scheduler #(
  parameter int unsigned MAX_TASKS = pts_pkg::PTS_MAX_TASKS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [pts_pkg::DIV_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [pts_pkg::CNT_W-1:0]  first_count_i,
  input  logic [pts_pkg::CNT_W-1:0]  period_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pts_pkg::MASK_W-1:0] due_mask_o,
  output logic                       tick_fired_o,
  output logic [pts_pkg::SLOT_W-1:0] assigned_slot_o,
  output logic                       table_full_o
);

  import pts_pkg::*;

  action_e    action;
  logic       in_accept;
  logic       out_take;
  logic       tick;
  tbl_req_t   tbl_req;
  tbl_stat_t  tbl_stat;

  logic              out_valid_q, out_valid_d;
  logic [MASK_W-1:0] due_q, due_d;
  logic              fired_q, fired_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              full_q, full_d;

  assign action      = action_e'(action_i);
  assign cfg_ready_o = 1'b1;
  assign out_take    = out_valid_q && !out_stall_i;
  assign in_stall_o  = tbl_stat.busy || (out_valid_q && out_stall_i);
  assign in_accept   = in_valid_i && !in_stall_o;

  pts_prescaler u_prescaler (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .step_i     (in_accept && (action == ACT_OVERFLOW)),
    .tick_o     (tick)
  );

  // Table request: registration or a tick walk
  always_comb begin
    tbl_req.valid       = 1'b0;
    tbl_req.op          = TOP_REGISTER;
    tbl_req.first_count = first_count_i;
    tbl_req.period      = period_i;
    if (in_accept && (action == ACT_REGISTER)) begin
      tbl_req.valid = 1'b1;
    end else if (tick) begin
      tbl_req.valid = 1'b1;
      tbl_req.op    = TOP_TICK;
    end
  end

  pts_slot_table #(
    .MAX_TASKS (MAX_TASKS)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .stat_o (tbl_stat)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q && !out_take;
    due_d       = due_q;
    fired_d     = fired_q;
    slot_d      = slot_q;
    full_d      = full_q;
    if (tbl_stat.done) begin
      out_valid_d = 1'b1;
      due_d       = tbl_stat.due_mask;
      fired_d     = 1'b1;
      slot_d      = '0;
      full_d      = 1'b0;
    end else if (in_accept && !tick) begin
      out_valid_d = 1'b1;
      due_d       = '0;
      fired_d     = 1'b0;
      slot_d      = '0;
      full_d      = 1'b0;
      case (action)
        ACT_REGISTER: begin
          slot_d = tbl_stat.found ? tbl_stat.free_slot : '0;
          full_d = !tbl_stat.found;
        end
        ACT_CHECK:    due_d = tbl_stat.due_mask;
        default:      due_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    due_q   <= due_d;
    fired_q <= fired_d;
    slot_q  <= slot_d;
    full_q  <= full_d;
  end

  assign out_valid_o     = out_valid_q;
  assign due_mask_o      = due_q;
  assign tick_fired_o    = fired_q;
  assign assigned_slot_o = slot_q;
  assign table_full_o    = full_q;

  // A finished walk always finds the result register free
  a_done_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_stat.done |-> !out_valid_q)
    else $error("walk finished while a result was still held");

  // A tick starts the walk on the next cycle
  a_tick_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> tbl_stat.busy)
    else $error("tick did not start the slot walk");

  // A fired tick never carries registration fields
  a_fired_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tick_fired_o) |-> (!table_full_o && (assigned_slot_o == '0)))
    else $error("tick result carries registration fields");

endmodule
